@@ rtl/core/tmq_pkg.sv @@
// Timed event queue: shared types, constants and codes.
// Depends on nothing; every module in rtl/core imports it.
`timescale 1ns / 1ps

package tmq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_CANCEL   = 2'd1,
    FUNC_CONTAINS = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] delay;
    logic [31:0] event_id;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic        head_valid;
    logic [63:0] head_time;
    logic [31:0] head_id;
  } rsp_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] count;
  } eng_stat_t;

endpackage

@@ rtl/core/tmq_mem.sv @@
// Timed event queue: entry store, one write port, one registered read port.
// Depends on tmq_pkg.
`timescale 1ns / 1ps

module tmq_mem (
  input  logic              clk,
  input  tmq_pkg::mem_req_t mem_req,
  output tmq_pkg::entry_t   rdata
);
  import tmq_pkg::*;

  entry_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      store[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[mem_req.raddr];
  end

endmodule

@@ rtl/core/tmq_walk.sv @@
// Timed event queue: sequencer that walks the sorted store one entry a cycle.
// Depends on tmq_pkg; drives tmq_mem through a mem_req_t.
`timescale 1ns / 1ps

module tmq_walk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tmq_pkg::req_t      req,
  input  logic               take,
  input  tmq_pkg::entry_t    rdata,
  output tmq_pkg::mem_req_t  mem_req,
  output tmq_pkg::rsp_t      result,
  output tmq_pkg::eng_stat_t stat
);
  import tmq_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  func_t            op, op_next;
  logic [63:0]      ts, ts_next;
  logic [31:0]      id, id_next;
  entry_t           carry, carry_next;
  logic             hit, hit_next;
  logic             status, status_next;
  logic             found, found_next;
  entry_t           head;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] pos_dec;
  logic             last;

  assign pos_inc = pos + CNT_W'(1);
  assign pos_dec = pos - CNT_W'(1);
  assign last    = (pos == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    op     <= op_next;
    ts     <= ts_next;
    id     <= id_next;
    carry  <= carry_next;
    hit    <= hit_next;
    status <= status_next;
    found  <= found_next;
  end

  // entry 0 mirrored so the head costs no extra read
  always_ff @(posedge clk) begin
    if (mem_req.we && (mem_req.waddr == '0)) begin
      head <= mem_req.wdata;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    op_next       = op;
    ts_next       = ts;
    id_next       = id;
    carry_next    = carry;
    hit_next      = hit;
    status_next   = status;
    found_next    = found;
    mem_req.we    = 1'b0;
    mem_req.waddr = pos[IDX_W-1:0];
    mem_req.wdata = carry;
    mem_req.raddr = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next     = req.func;
          ts_next     = req.now + {32'd0, req.delay};
          id_next     = req.event_id;
          pos_next    = '0;
          hit_next    = 1'b0;
          status_next = 1'b0;
          found_next  = 1'b0;
          state_next  = ST_WALK;
          if (req.func == FUNC_CLEAR) begin
            count_next = '0;
            state_next = ST_DONE;
          end else if ((req.func == FUNC_ADD) && (count == CNT_W'(DEPTH))) begin
            status_next = 1'b1;
            state_next  = ST_DONE;
          end
        end
      end

      ST_WALK: begin
        // rdata holds entry pos; prefetch the next one
        mem_req.raddr = pos_inc[IDX_W-1:0];
        pos_next      = pos_inc;
        if (op == FUNC_ADD) begin
          if (last) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = hit ? carry : entry_t'{stamp: ts, tag: id};
            count_next    = count + CNT_W'(1);
            state_next    = ST_DONE;
          end else if (hit) begin
            // ripple the tail up by one slot
            mem_req.we = 1'b1;
            carry_next = rdata;
          end else if (ts == rdata.stamp) begin
            ts_next = ts + 64'd1;
          end else if (ts < rdata.stamp) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = entry_t'{stamp: ts, tag: id};
            carry_next    = rdata;
            hit_next      = 1'b1;
          end
        end else begin
          if (last) begin
            found_next = hit;
            if ((op == FUNC_CANCEL) && hit) begin
              count_next = count - CNT_W'(1);
            end
            state_next = ST_DONE;
          end else if (hit) begin
            // on cancel, close the gap left by the removed entry
            mem_req.we    = (op == FUNC_CANCEL);
            mem_req.waddr = pos_dec[IDX_W-1:0];
            mem_req.wdata = rdata;
          end else if (rdata.tag == id) begin
            hit_next = 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result.status     = status;
    result.found      = found;
    result.head_valid = (count != '0);
    result.head_time  = (count != '0) ? head.stamp : 64'd0;
    result.head_id    = (count != '0) ? head.tag : 32'd0;
  end

  assign stat.busy  = (state != ST_IDLE);
  assign stat.done  = (state == ST_DONE);
  assign stat.count = count;

endmodule

@@ rtl/core/timed_event_queue_top.sv @@
// Timed event queue top level: request/response channels around the sequencer.
// Depends on tmq_pkg, tmq_mem and tmq_walk.
//
// Usage:
//  - Request channel (req_valid/req_stall/req): one beat per operation:
//    add, cancel, contains or clear, with delay, event id and current time.
//  - Response channel (rsp_valid/rsp_stall/rsp): exactly one beat per
//    request, in order: add-dropped status, found flag and the queue head.
//  - Entries sit in a 16-deep synchronous store, kept sorted by timestamp.
//    Add and cancel walk it one entry per cycle, shifting the tail as they go.
//  - Clear and a dropped add go to the response register without a walk;
//    add, cancel and contains first walk the store once over its count
//    entries (count is the number held, at most DEPTH = 16). One request
//    at a time: the next is taken the cycle after the response loads.
//  - req_stall stays high while an operation is in flight or its response
//    cannot yet move into the output register.
//  - A stalled response holds in rsp; the finished operation waits for it.
//  - Reset (rst, synchronous) empties the queue; the store is not cleared.
`timescale 1ns / 1ps

module timed_event_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tmq_pkg::rsp_t rsp
);
  import tmq_pkg::*;

  mem_req_t  mem_req;
  entry_t    rdata;
  rsp_t      result;
  eng_stat_t stat;
  logic      start;
  logic      take;

  // sequencer takes a request only when idle
  assign req_stall = stat.busy;
  assign start     = req_valid && !req_stall;

  // result moves into the output register when it is free or being drained
  assign take = stat.done && (!rsp_valid || !rsp_stall);

  tmq_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  tmq_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .take    (take),
    .rdata   (rdata),
    .mem_req (mem_req),
    .result  (result),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= result;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(DEPTH))
    else $error("entry count beyond queue depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (start && (req.func == FUNC_CLEAR)) |=> (stat.count == '0))
    else $error("clear did not empty the queue");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (!stat.busy && !start) |=> $stable(stat.count))
    else $error("entry count changed while idle");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (stat.done && !take) |=> stat.done)
    else $error("finished result dropped before the output took it");
`endif

endmodule
